FILE: rtl/deglitched_pulse_frequency_counter_macros.svh
// Assertion macros used by the checker of the pulse frequency counter.
`ifndef DEGLITCHED_PULSE_FREQUENCY_COUNTER_MACROS_SVH
`define DEGLITCHED_PULSE_FREQUENCY_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define DPFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpfc check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define DPFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpfc check failed: next-cycle implication");

`endif

FILE: rtl/dpfc_pkg.sv
// Types and constants shared by the pulse frequency counter modules.
package dpfc_pkg;

    localparam int DPFC_WINDOW_DEF = 11;
    localparam int SAMPLE_W        = 12;
    localparam int COUNT_W         = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd683;
    localparam logic [COUNT_W-1:0]  PERIOD_RST    = 16'd15625;
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESHOLD = 2'd0,
        CFG_GATE_PERIOD   = 2'd1,
        CFG_DRAW_PERIOD   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic               filtered_low;
        logic               window_ready;
        logic [COUNT_W-1:0] pulses_last_gate;
        logic               gate_done;
        logic               refresh_tick;
    } result_t;

endpackage

FILE: rtl/dpfc_cell.sv
// One window cell: holds one classification bit and its fill mark.
module dpfc_cell
    import dpfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic shift_en,
    input  logic bit_in,
    input  logic fill_in,
    output logic bit_out,
    output logic fill_out
);

    logic bit_reg;
    logic fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= 1'b0;
            fill_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            bit_reg  <= bit_in;
            fill_reg <= fill_in;
        end
    end

    assign bit_out  = bit_reg;
    assign fill_out = fill_reg;

endmodule

FILE: rtl/dpfc_tick_cnt.sv
// Wrapping tick counter that flags the tick on which it meets its period.
module dpfc_tick_cnt
    import dpfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [COUNT_W-1:0] period,
    output logic               hit
);

    logic [COUNT_W-1:0] ticks_reg;
    logic [COUNT_W-1:0] ticks_next;

    always_comb
    begin
        hit = (ticks_reg == period);
        if (hit)
        begin
            ticks_next = '0;
        end
        else
        begin
            ticks_next = ticks_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= '0;
        end
        else if (step)
        begin
            ticks_reg <= ticks_next;
        end
    end

endmodule

FILE: rtl/dpfc_out_buf.sv
// Two-entry output buffer that decouples result delivery from sample intake.
module dpfc_out_buf
    import dpfc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_word,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_word
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_word_reg;
    result_t skid_word_reg;
    logic    take;

    assign take = main_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_word_reg <= skid_word_reg;
            end
            else if (push)
            begin
                main_word_reg <= push_word;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_word_reg <= push_word;
            end
            else
            begin
                main_word_reg <= push_word;
            end
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_word_reg;

endmodule

FILE: rtl/deglitched_pulse_frequency_counter.sv
// Top level of the deglitched pulse frequency counter.
// The block takes one sample per clock cycle while in_stall is low and returns one result
// word for each sample, registered once the sample is accepted. A two-entry output buffer
// lets intake continue while a result waits; in_stall rises only when both entries hold
// words. The window is a chain of WINDOW cells shifted once per sample, and the count of
// low bits in it is kept as a running sum, so the per-sample path is one small add and
// compare. Configuration writes are always ready and take effect on the next sample.
module deglitched_pulse_frequency_counter
    import dpfc_pkg::*;
#(
    parameter int WINDOW = DPFC_WINDOW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  filtered_low,
    output logic                  window_ready,
    output logic [COUNT_W-1:0]    pulses_last_gate,
    output logic                  gate_done,
    output logic                  refresh_tick,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LOWS_W = $clog2(WINDOW + 1);

    logic [SAMPLE_W-1:0] low_threshold_reg;
    logic [COUNT_W-1:0]  gate_period_reg;
    logic [COUNT_W-1:0]  draw_period_reg;

    logic               accept;
    logic               buf_full;
    logic               refresh_hit;
    logic               gate_hit;
    logic               new_bit;
    logic [WINDOW:0]    bit_chain;
    logic [WINDOW:0]    fill_chain;
    logic               ready_next;
    logic               filt;
    logic [LOWS_W-1:0]  lows_reg;
    logic [LOWS_W-1:0]  lows_next;
    logic [COUNT_W-1:0] pulse_count_reg;
    logic [COUNT_W-1:0] pulse_count_next;
    logic [COUNT_W-1:0] pulse_base;
    logic [COUNT_W-1:0] latched_count_reg;
    logic [COUNT_W-1:0] latched_count_next;
    logic               low_state_reg;
    logic               low_state_next;
    result_t            result_word;
    result_t            out_word;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign accept    = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_threshold_reg <= THRESHOLD_RST;
            gate_period_reg   <= PERIOD_RST;
            draw_period_reg   <= PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LOW_THRESHOLD: low_threshold_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_GATE_PERIOD:   gate_period_reg   <= cfg_data[COUNT_W-1:0];
                CFG_DRAW_PERIOD:   draw_period_reg   <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    dpfc_tick_cnt u_draw_cnt (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .period (draw_period_reg),
        .hit    (refresh_hit)
    );

    dpfc_tick_cnt u_gate_cnt (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .period (gate_period_reg),
        .hit    (gate_hit)
    );

    assign new_bit       = (sample < low_threshold_reg);
    assign bit_chain[0]  = new_bit;
    assign fill_chain[0] = 1'b1;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        dpfc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (accept),
            .bit_in   (bit_chain[i]),
            .fill_in  (fill_chain[i]),
            .bit_out  (bit_chain[i+1]),
            .fill_out (fill_chain[i+1])
        );
    end

    assign ready_next = fill_chain[WINDOW-1];

    always_comb
    begin
        lows_next = lows_reg + LOWS_W'(bit_chain[0]) - LOWS_W'(bit_chain[WINDOW]);
        filt      = ready_next && ({lows_next, 1'b0} >= (LOWS_W + 1)'(WINDOW));

        if (gate_hit)
        begin
            pulse_base         = '0;
            latched_count_next = pulse_count_reg;
        end
        else
        begin
            pulse_base         = pulse_count_reg;
            latched_count_next = latched_count_reg;
        end

        pulse_count_next = pulse_base;
        low_state_next   = low_state_reg;
        if (ready_next)
        begin
            if (filt && !low_state_reg && (pulse_base != COUNT_MAX))
            begin
                pulse_count_next = pulse_base + 1'b1;
            end
            low_state_next = filt;
        end

        result_word.filtered_low     = filt;
        result_word.window_ready     = ready_next;
        result_word.pulses_last_gate = latched_count_next;
        result_word.gate_done        = gate_hit;
        result_word.refresh_tick     = refresh_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lows_reg          <= '0;
            pulse_count_reg   <= '0;
            latched_count_reg <= '0;
            low_state_reg     <= 1'b0;
        end
        else if (accept)
        begin
            lows_reg          <= lows_next;
            pulse_count_reg   <= pulse_count_next;
            latched_count_reg <= latched_count_next;
            low_state_reg     <= low_state_next;
        end
    end

    dpfc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (result_word),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign filtered_low     = out_word.filtered_low;
    assign window_ready     = out_word.window_ready;
    assign pulses_last_gate = out_word.pulses_last_gate;
    assign gate_done        = out_word.gate_done;
    assign refresh_tick     = out_word.refresh_tick;

endmodule

FILE: rtl/dpfc_checker.sv
// Port-level checker for the pulse frequency counter and its bind.
`include "deglitched_pulse_frequency_counter_macros.svh"

module dpfc_checker
    import dpfc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               filtered_low,
    input logic               window_ready,
    input logic [COUNT_W-1:0] pulses_last_gate,
    input logic               gate_done,
    input logic               refresh_tick,
    input logic               cfg_ready
);

    `DPFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pulses_last_gate))
    `DPFC_ASSERT_NOW(a_filt_needs_ready, clk, rst_n, out_valid, !filtered_low || window_ready)
    `DPFC_ASSERT_NOW(a_stall_has_word, clk, rst_n, in_stall, out_valid)
    `DPFC_ASSERT_NEXT(a_ready_sticks, clk, rst_n, out_valid && !out_stall && window_ready, !out_valid || window_ready)
    `DPFC_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind deglitched_pulse_frequency_counter dpfc_checker u_dpfc_checker (.*);

FILE: dv/tb_deglitched_pulse_frequency_counter.sv
// Self-checking testbench for the deglitched pulse frequency counter.
module tb_deglitched_pulse_frequency_counter;
    import dpfc_pkg::*;

    localparam int WIN = DPFC_WINDOW_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample;
    logic                  out_valid;
    logic                  out_stall;
    logic                  filtered_low;
    logic                  window_ready;
    logic [COUNT_W-1:0]    pulses_last_gate;
    logic                  gate_done;
    logic                  refresh_tick;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [SAMPLE_W-1:0] threshold;
    logic [COUNT_W-1:0]  gate_period;
    logic [COUNT_W-1:0]  draw_period;
    logic [COUNT_W-1:0]  gate_ticks;
    logic [COUNT_W-1:0]  draw_ticks;
    logic [COUNT_W-1:0]  pulse_tally;
    logic [COUNT_W-1:0]  latched_tally;
    logic [WIN-1:0]      win_bits;
    int                  fill_cnt;
    logic                low_state;

    result_t counter_outputs_due[$];
    bit      idle_en;
    int      stall_left;
    int      mismatches;
    int      samples_sent;
    int      words_checked;
    int      gates_seen;
    int      refreshes_seen;
    int      lows_seen;
    int      peak_latched;

    deglitched_pulse_frequency_counter u_dut (.*);

    always #5 clk = ~clk;

    function automatic result_t step_pulse_counter(input logic [SAMPLE_W-1:0] s);
        result_t r;
        r = '0;
        r.refresh_tick = (draw_ticks == draw_period);
        draw_ticks = r.refresh_tick ? '0 : draw_ticks + 1'b1;
        r.gate_done = (gate_ticks == gate_period);
        if (r.gate_done)
        begin
            latched_tally = pulse_tally;
            pulse_tally = '0;
            gate_ticks = '0;
        end
        else
        begin
            gate_ticks = gate_ticks + 1'b1;
        end
        win_bits = {win_bits[WIN-2:0], s < threshold};
        if (fill_cnt < WIN)
            fill_cnt++;
        r.window_ready = (fill_cnt >= WIN);
        if (r.window_ready)
        begin
            r.filtered_low = (2 * $countones(win_bits) >= WIN);
            if (r.filtered_low && !low_state && pulse_tally != COUNT_MAX)
                pulse_tally = pulse_tally + 1'b1;
            low_state = r.filtered_low;
        end
        r.pulses_last_gate = latched_tally;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] level_sample(input bit want_low);
        if (want_low && threshold != 0)
            return SAMPLE_W'($urandom_range(0, threshold - 1));
        if (!want_low)
            return SAMPLE_W'($urandom_range(threshold, 4095));
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        cfg_valid <= 1'b0;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        counter_outputs_due.push_back(step_pulse_counter(s));
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LOW_THRESHOLD: threshold = data[SAMPLE_W-1:0];
            CFG_GATE_PERIOD:   gate_period = data;
            CFG_DRAW_PERIOD:   draw_period = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (counter_outputs_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk)
    begin
        if (!idle_en)
            stall_left = 0;
        else if (stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (counter_outputs_due.size() == 0)
            begin
                $error("Result word arrived with no sample outstanding.");
                mismatches++;
            end
            else
            begin
                want = counter_outputs_due.pop_front();
                compare_field("filtered_low", want.filtered_low, filtered_low);
                compare_field("window_ready", want.window_ready, window_ready);
                compare_field("pulses_last_gate", want.pulses_last_gate, pulses_last_gate);
                compare_field("gate_done", want.gate_done, gate_done);
                compare_field("refresh_tick", want.refresh_tick, refresh_tick);
                words_checked++;
                gates_seen += want.gate_done;
                refreshes_seen += want.refresh_tick;
                lows_seen += want.filtered_low;
                if (want.pulses_last_gate > peak_latched)
                    peak_latched = want.pulses_last_gate;
            end
        end
    end

    task automatic test_window_fill();
        logic [SAMPLE_W-1:0] pattern [11];
        pattern = '{12'd0, 12'd4095, 12'd682, 12'd683, 12'hAAA, 12'h555,
                    12'd0, 12'd1, 12'd0, 12'd4095, 12'd0};
        foreach (pattern[i])
            send_sample(pattern[i]);
    endtask

    task automatic test_register_edges();
        wait_idle();
        write_reg(CFG_LOW_THRESHOLD, 16'hF000);
        write_reg(CFG_GATE_PERIOD, 16'd0);
        write_reg(CFG_DRAW_PERIOD, 16'd0);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'h800);
        send_sample(12'd1);
        wait_idle();
        write_reg(CFG_SPARE, 16'hFFFF);
        send_sample(12'd0);
        send_sample(12'd0);
        wait_idle();
        write_reg(CFG_LOW_THRESHOLD, 16'h0FFF);
        write_reg(CFG_GATE_PERIOD, 16'hFFFF);
        write_reg(CFG_DRAW_PERIOD, 16'hFFFF);
        send_sample(12'd4095);
        send_sample(12'd4094);
        send_sample(12'd0);
        send_sample(12'hFFE);
        wait_idle();
        write_reg(CFG_LOW_THRESHOLD, 16'd683);
        write_reg(CFG_GATE_PERIOD, 16'd1);
        write_reg(CFG_DRAW_PERIOD, 16'd2);
        for (int n = 0; n < 6; n++)
            send_sample(n[0] ? 12'd4095 : 12'd0);
    endtask

    task automatic test_random_traffic();
        int  run_left;
        bit  level;
        logic [SAMPLE_W-1:0] thr;
        run_left = 0;
        level = 1'b0;
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            idle_en = (phase < 6);
            case ($urandom_range(0, 4))
                0:       thr = '0;
                1:       thr = 12'd4095;
                2:       thr = THRESHOLD_RST;
                default: thr = SAMPLE_W'($urandom_range(1, 4095));
            endcase
            write_reg(CFG_LOW_THRESHOLD, {4'($urandom), thr});
            for (int k = 0; k < 2; k++)
            begin
                logic [COUNT_W-1:0] per;
                case ($urandom_range(0, 5))
                    0:       per = '0;
                    1:       per = COUNT_MAX;
                    2:       per = 16'd1;
                    default: per = COUNT_W'($urandom_range(2, 60));
                endcase
                write_reg(k == 0 ? CFG_GATE_PERIOD : CFG_DRAW_PERIOD, per);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            for (int n = 0; n < 240; n++)
            begin
                if (run_left == 0)
                begin
                    level = ~level;
                    run_left = $urandom_range(1, 20);
                end
                run_left--;
                case ($urandom_range(0, 9))
                    0, 1:    send_sample(SAMPLE_W'($urandom));
                    2:       send_sample(level_sample(!level));
                    default: send_sample(level_sample(level));
                endcase
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LOW_THRESHOLD;
        cfg_data = '0;
        threshold = THRESHOLD_RST;
        gate_period = PERIOD_RST;
        draw_period = PERIOD_RST;
        gate_ticks = '0;
        draw_ticks = '0;
        pulse_tally = '0;
        latched_tally = '0;
        win_bits = '0;
        fill_cnt = 0;
        low_state = 1'b0;
        idle_en = 1'b1;
        stall_left = 0;
        mismatches = 0;
        samples_sent = 0;
        words_checked = 0;
        gates_seen = 0;
        refreshes_seen = 0;
        lows_seen = 0;
        peak_latched = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_window_fill();
        test_register_edges();
        test_random_traffic();
        wait_idle();

        $display("Summary: %0d samples sent and %0d result words checked over thresholds",
                 samples_sent, words_checked);
        $display("and periods from zero to full scale; %0d gates (peak %0d), %0d refreshes.",
                 gates_seen, peak_latched, refreshes_seen);
        if (mismatches == 0 && counter_outputs_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
